/* hw/rtl/tma_pkg.sv */
package tma_pkg;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_TRI  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   localparam logic signed [31:0] LIM31   = 32'sh7FFF_FFFF;
   localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

   typedef logic signed [31:0] q16_type;
   typedef logic signed [47:0] acc_type;
   typedef logic signed [15:0] q14_type;

   typedef struct packed {
      q16_type x;
      q16_type y;
      q16_type z;
      q16_type u;
      q16_type v;
   } vtx_type;

   typedef struct packed {
      acc_type x;
      acc_type y;
      acc_type z;
   } acc_vec_type;

   function automatic q16_type sat_diff(input q16_type a, input q16_type b);
      logic signed [32:0] d;
      d = 33'(b) - 33'(a);
      if (d > 33'sd2147483647)
         sat_diff = LIM31;
      else if (d < -33'sd2147483647)
         sat_diff = -LIM31;
      else
         sat_diff = d[31:0];
   endfunction

   function automatic vtx_type vtx_diff(input vtx_type a, input vtx_type b);
      vtx_type r;
      r.x = sat_diff(a.x, b.x);
      r.y = sat_diff(a.y, b.y);
      r.z = sat_diff(a.z, b.z);
      r.u = sat_diff(a.u, b.u);
      r.v = sat_diff(a.v, b.v);
      vtx_diff = r;
   endfunction

   function automatic logic [30:0] mag31(input q16_type a);
      logic [31:0] n;
      n = -a;
      mag31 = a[31] ? n[30:0] : a[30:0];
   endfunction

   function automatic logic [47:0] mag48(input acc_type a);
      logic [47:0] n;
      n = -a;
      mag48 = a[47] ? n : a;
   endfunction

   function automatic acc_type sat_add(input acc_type a, input acc_type b);
      logic signed [48:0] s;
      s = 49'(a) + 49'(b);
      if (s > 49'(ACC_MAX))
         sat_add = ACC_MAX;
      else if (s < 49'(ACC_MIN))
         sat_add = ACC_MIN;
      else
         sat_add = s[47:0];
   endfunction

   function automatic acc_type sat_quot(input logic [62:0] q, input logic neg);
      if (q[62:47] != '0)
         sat_quot = neg ? ACC_MIN : ACC_MAX;
      else if (neg)
         sat_quot = -$signed({1'b0, q[46:0]});
      else
         sat_quot = $signed({1'b0, q[46:0]});
   endfunction

endpackage

/* hw/rtl/tma_req_if.sv */
interface tma_req_if;
   import tma_pkg::*;

   logic          valid;
   logic          ready;
   logic [1:0]    cmd;
   logic [9:0]    vertex_index;
   q16_type       pos_x;
   q16_type       pos_y;
   q16_type       pos_z;
   q16_type       tex_u;
   q16_type       tex_v;
   logic [9:0]    corner_a;
   logic [9:0]    corner_b;
   logic [9:0]    corner_c;

   modport source (
      output valid, cmd, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
             corner_a, corner_b, corner_c,
      input  ready
   );

   modport sink (
      input  valid, cmd, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
             corner_a, corner_b, corner_c,
      output ready
   );
endinterface

/* hw/rtl/tma_rsp_if.sv */
interface tma_rsp_if;
   import tma_pkg::*;

   logic     valid;
   logic     ready;
   q14_type  tangent_x;
   q14_type  tangent_y;
   q14_type  tangent_z;
   logic     is_zero;

   modport source (
      output valid, tangent_x, tangent_y, tangent_z, is_zero,
      input  ready
   );

   modport sink (
      input  valid, tangent_x, tangent_y, tangent_z, is_zero,
      output ready
   );
endinterface

/* hw/rtl/mesh_tangent_accumulate_top.sv */
// Load: written into the stores from idle. Triangle: three position reads, eight 31-step
// serial multiplies and, unless the determinant is zero, three 63-step serial divides and
// three memory read-modify-writes. Read-out: up to 18 shift steps, three squares, a
// 31-step square root, three 63-step divides; one result word each.
// One item in flight at a time; a finished word waits in the output register.
// Synchronous reset clears control state; vertex and tangent stores are not cleared.
module mesh_tangent_accumulate_top #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   tma_req_if.sink           req_ch,
   tma_rsp_if.source         rsp_ch
);
   import tma_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);

   typedef enum logic [15:0] {
      S_IDLE      = 16'b0000_0000_0000_0001,
      S_POS_RD    = 16'b0000_0000_0000_0010,
      S_POS_CAP   = 16'b0000_0000_0000_0100,
      S_MUL_GO    = 16'b0000_0000_0000_1000,
      S_MUL_WAIT  = 16'b0000_0000_0001_0000,
      S_CALC      = 16'b0000_0000_0010_0000,
      S_DIV_GO    = 16'b0000_0000_0100_0000,
      S_DIV_WAIT  = 16'b0000_0000_1000_0000,
      S_ACC_RD    = 16'b0000_0001_0000_0000,
      S_ACC_WR    = 16'b0000_0010_0000_0000,
      S_RO_RD     = 16'b0000_0100_0000_0000,
      S_RO_CHK    = 16'b0000_1000_0000_0000,
      S_RO_SHIFT  = 16'b0001_0000_0000_0000,
      S_SQRT_GO   = 16'b0010_0000_0000_0000,
      S_SQRT_WAIT = 16'b0100_0000_0000_0000,
      S_OUT       = 16'b1000_0000_0000_0000
   } state_type;

   function automatic logic in_range(input logic [9:0] idx);
      in_range = (32'(idx) < MAX_VERTICES);
   endfunction

   state_type          state_ff, state_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [9:0]         vi_ff, vi_in;
   logic [9:0]         cor_ff [3];
   logic [9:0]         cor_in [3];
   logic [1:0]         k_ff, k_in;
   logic [2:0]         idx_ff, idx_in;
   vtx_type            p0_ff, p0_in;
   vtx_type            d1_ff, d1_in;
   vtx_type            d2_ff, d2_in;
   logic signed [46:0] prod_ff [8];
   logic signed [46:0] prod_in [8];
   acc_type            det_ff, det_in;
   acc_type            num_ff [3];
   acc_type            num_in [3];
   acc_type            t_ff [3];
   acc_type            t_in [3];
   logic [47:0]        mag_ff [3];
   logic [47:0]        mag_in [3];
   logic [2:0]         sgn_ff, sgn_in;
   logic [61:0]        sq_ff, sq_in;
   logic [30:0]        len_ff, len_in;
   q14_type            out_ff [3];
   q14_type            out_in [3];
   logic               zero_ff, zero_in;
   logic               rsp_valid_ff, rsp_valid_in;
   q14_type            rsp_x_ff, rsp_x_in;
   q14_type            rsp_y_ff, rsp_y_in;
   q14_type            rsp_z_ff, rsp_z_in;
   logic               rsp_zero_ff, rsp_zero_in;

   vtx_type            pos_mem_ff [MAX_VERTICES];
   acc_vec_type        acc_mem_ff [MAX_VERTICES];
   vtx_type            pos_rd_ff;
   acc_vec_type        acc_rd_ff;

   logic               pos_we, acc_we, pos_re, acc_re;
   logic [AW-1:0]      wr_addr, rd_addr;
   vtx_type            pos_wdata;
   acc_vec_type        acc_wdata;

   logic               mul_start, mul_busy, mul_done;
   logic [30:0]        mul_a, mul_b;
   logic [61:0]        mul_product;
   q16_type            mul_sa, mul_sb;
   logic               mul_neg;
   logic [45:0]        prod_mag;

   logic               div_start, div_done;
   logic [62:0]        div_n;
   logic [46:0]        div_d;
   logic [62:0]        div_q;
   logic [47:0]        num_mag;
   logic [47:0]        det_mag;

   logic               sqrt_start, sqrt_done;
   logic [30:0]        sqrt_root;

   acc_type            det_c;
   logic               out_fire;

   tma_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_product)
   );

   tma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   tma_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   always_comb begin
      case (idx_ff)
         3'd0: begin mul_sa = d1_ff.u; mul_sb = d2_ff.v; end
         3'd1: begin mul_sa = d2_ff.u; mul_sb = d1_ff.v; end
         3'd2: begin mul_sa = d2_ff.v; mul_sb = d1_ff.x; end
         3'd3: begin mul_sa = d1_ff.v; mul_sb = d2_ff.x; end
         3'd4: begin mul_sa = d2_ff.v; mul_sb = d1_ff.y; end
         3'd5: begin mul_sa = d1_ff.v; mul_sb = d2_ff.y; end
         3'd6: begin mul_sa = d2_ff.v; mul_sb = d1_ff.z; end
         3'd7: begin mul_sa = d1_ff.v; mul_sb = d2_ff.z; end
         default: begin mul_sa = d1_ff.v; mul_sb = d2_ff.z; end
      endcase
      if (cmd_ff == CMD_READ) begin
         mul_a = mag_ff[idx_ff[1:0]][30:0];
         mul_b = mag_ff[idx_ff[1:0]][30:0];
      end else begin
         mul_a = mag31(mul_sa);
         mul_b = mag31(mul_sb);
      end
      mul_neg  = mul_sa[31] ^ mul_sb[31];
      prod_mag = mul_product[61:16];
   end

   always_comb begin
      num_mag = mag48(num_ff[k_ff]);
      det_mag = mag48(det_ff);
      if (cmd_ff == CMD_READ) begin
         div_n = 63'({mag_ff[k_ff][29:0], 14'd0});
         div_d = 47'(len_ff);
      end else begin
         div_n = {num_mag[46:0], 16'd0};
         div_d = det_mag[46:0];
      end
   end

   assign det_c    = 48'(prod_ff[0]) - 48'(prod_ff[1]);
   assign out_fire = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      vi_in        = vi_ff;
      cor_in       = cor_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      p0_in        = p0_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      prod_in      = prod_ff;
      det_in       = det_ff;
      num_in       = num_ff;
      t_in         = t_ff;
      mag_in       = mag_ff;
      sgn_in       = sgn_ff;
      sq_in        = sq_ff;
      len_in       = len_ff;
      out_in       = out_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_zero_in  = rsp_zero_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      sqrt_start   = 1'b0;
      pos_we       = 1'b0;
      acc_we       = 1'b0;
      pos_re       = 1'b0;
      acc_re       = 1'b0;
      wr_addr      = AW'(cor_ff[k_ff]);
      rd_addr      = AW'(cor_ff[k_ff]);
      pos_wdata    = {req_ch.pos_x, req_ch.pos_y, req_ch.pos_z, req_ch.tex_u, req_ch.tex_v};
      acc_wdata.x  = sat_add(acc_rd_ff.x, t_ff[0]);
      acc_wdata.y  = sat_add(acc_rd_ff.y, t_ff[1]);
      acc_wdata.z  = sat_add(acc_rd_ff.z, t_ff[2]);

      case (state_ff)
         S_IDLE: begin
            wr_addr = AW'(req_ch.vertex_index);
            if (req_ch.valid) begin
               cmd_in    = req_ch.cmd;
               vi_in     = req_ch.vertex_index;
               cor_in[0] = req_ch.corner_a;
               cor_in[1] = req_ch.corner_b;
               cor_in[2] = req_ch.corner_c;
               case (req_ch.cmd)
                  CMD_LOAD: begin
                     if (in_range(req_ch.vertex_index)) begin
                        pos_we    = 1'b1;
                        acc_we    = 1'b1;
                        acc_wdata = '0;
                     end
                  end
                  CMD_TRI: begin
                     if (in_range(req_ch.corner_a) && in_range(req_ch.corner_b) &&
                         in_range(req_ch.corner_c)) begin
                        k_in     = 2'd0;
                        state_in = S_POS_RD;
                     end
                  end
                  CMD_READ: begin
                     if (in_range(req_ch.vertex_index)) begin
                        state_in = S_RO_RD;
                     end else begin
                        out_in   = '{default: '0};
                        zero_in  = 1'b1;
                        state_in = S_OUT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_POS_RD: begin
            pos_re   = 1'b1;
            state_in = S_POS_CAP;
         end
         S_POS_CAP: begin
            case (k_ff)
               2'd0:    p0_in = pos_rd_ff;
               2'd1:    d1_in = vtx_diff(p0_ff, pos_rd_ff);
               default: d2_in = vtx_diff(p0_ff, pos_rd_ff);
            endcase
            if (k_ff == 2'd2) begin
               idx_in   = 3'd0;
               state_in = S_MUL_GO;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_POS_RD;
            end
         end
         S_MUL_GO: begin
            mul_start = 1'b1;
            state_in  = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (mul_done) begin
               if (cmd_ff == CMD_READ) begin
                  sq_in = sq_ff + mul_product;
                  if (idx_ff == 3'd2) begin
                     state_in = S_SQRT_GO;
                  end else begin
                     idx_in   = idx_ff + 3'd1;
                     state_in = S_MUL_GO;
                  end
               end else begin
                  prod_in[idx_ff] = mul_neg ? -$signed({1'b0, prod_mag})
                                            : $signed({1'b0, prod_mag});
                  if (idx_ff == 3'd7) begin
                     state_in = S_CALC;
                  end else begin
                     idx_in   = idx_ff + 3'd1;
                     state_in = S_MUL_GO;
                  end
               end
            end
         end
         S_CALC: begin
            det_in    = det_c;
            num_in[0] = 48'(prod_ff[2]) - 48'(prod_ff[3]);
            num_in[1] = 48'(prod_ff[4]) - 48'(prod_ff[5]);
            num_in[2] = 48'(prod_ff[6]) - 48'(prod_ff[7]);
            k_in      = 2'd0;
            state_in  = (det_c == '0) ? S_IDLE : S_DIV_GO;
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               if (cmd_ff == CMD_READ) begin
                  out_in[k_ff] = sgn_ff[k_ff] ? 16'(32'd0 - 32'(div_q[15:0]))
                                              : div_q[15:0];
                  if (k_ff == 2'd2) begin
                     zero_in  = 1'b0;
                     state_in = S_OUT;
                  end else begin
                     k_in     = k_ff + 2'd1;
                     state_in = S_DIV_GO;
                  end
               end else begin
                  t_in[k_ff] = sat_quot(div_q, num_ff[k_ff][47] ^ det_ff[47]);
                  if (k_ff == 2'd2) begin
                     k_in     = 2'd0;
                     state_in = S_ACC_RD;
                  end else begin
                     k_in     = k_ff + 2'd1;
                     state_in = S_DIV_GO;
                  end
               end
            end
         end
         S_ACC_RD: begin
            acc_re   = 1'b1;
            state_in = S_ACC_WR;
         end
         S_ACC_WR: begin
            acc_we = 1'b1;
            if (k_ff == 2'd2) begin
               state_in = S_IDLE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_ACC_RD;
            end
         end
         S_RO_RD: begin
            rd_addr  = AW'(vi_ff);
            acc_re   = 1'b1;
            state_in = S_RO_CHK;
         end
         S_RO_CHK: begin
            mag_in[0] = mag48(acc_rd_ff.x);
            mag_in[1] = mag48(acc_rd_ff.y);
            mag_in[2] = mag48(acc_rd_ff.z);
            sgn_in    = {acc_rd_ff.z[47], acc_rd_ff.y[47], acc_rd_ff.x[47]};
            if ((acc_rd_ff.x | acc_rd_ff.y | acc_rd_ff.z) == '0) begin
               out_in   = '{default: '0};
               zero_in  = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_RO_SHIFT;
            end
         end
         S_RO_SHIFT: begin
            if ((mag_ff[0][47:30] | mag_ff[1][47:30] | mag_ff[2][47:30]) != '0) begin
               mag_in[0] = mag_ff[0] >> 1;
               mag_in[1] = mag_ff[1] >> 1;
               mag_in[2] = mag_ff[2] >> 1;
            end else begin
               idx_in   = 3'd0;
               sq_in    = '0;
               state_in = S_MUL_GO;
            end
         end
         S_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in   = S_SQRT_WAIT;
         end
         S_SQRT_WAIT: begin
            if (sqrt_done) begin
               len_in = sqrt_root;
               k_in   = 2'd0;
               if (sqrt_root == '0) begin
                  out_in   = '{default: '0};
                  zero_in  = 1'b1;
                  state_in = S_OUT;
               end else begin
                  state_in = S_DIV_GO;
               end
            end
         end
         S_OUT: begin
            if (out_fire) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = out_ff[0];
               rsp_y_in     = out_ff[1];
               rsp_z_in     = out_ff[2];
               rsp_zero_in  = zero_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      vi_ff       <= vi_in;
      cor_ff      <= cor_in;
      k_ff        <= k_in;
      idx_ff      <= idx_in;
      p0_ff       <= p0_in;
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      prod_ff     <= prod_in;
      det_ff      <= det_in;
      num_ff      <= num_in;
      t_ff        <= t_in;
      mag_ff      <= mag_in;
      sgn_ff      <= sgn_in;
      sq_ff       <= sq_in;
      len_ff      <= len_in;
      out_ff      <= out_in;
      zero_ff     <= zero_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem_ff[wr_addr] <= pos_wdata;
      if (pos_re) pos_rd_ff <= pos_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (acc_we) acc_mem_ff[wr_addr] <= acc_wdata;
      if (acc_re) acc_rd_ff <= acc_mem_ff[rd_addr];
   end

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.tangent_x = rsp_x_ff;
   assign rsp_ch.tangent_y = rsp_y_ff;
   assign rsp_ch.tangent_z = rsp_z_ff;
   assign rsp_ch.is_zero   = rsp_zero_ff;

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ACC_WR |-> det_ff != '0)
      else $error("accumulate with zero determinant");

   assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_busy)
      else $error("multiplier restarted while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_zero_ff |->
         rsp_x_ff == '0 && rsp_y_ff == '0 && rsp_z_ff == '0)
      else $error("zero flag with nonzero tangent");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && out_fire |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("result word lost");
endmodule

/* hw/rtl/tma_mul.sv */
module tma_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] op_a,
   input  logic [30:0] op_b,
   output logic        busy,
   output logic        done,
   output logic [61:0] product
);
   logic [62:0] acc_ff, acc_in;
   logic [30:0] mcand_ff, mcand_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] sum;

   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      sum = {1'b0, acc_ff[62:31]} + (acc_ff[0] ? {2'b00, mcand_ff} : 33'd0);
      if (start) begin
         acc_in   = {32'd0, op_b};
         mcand_in = op_a;
         cnt_in   = 5'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in = {sum, acc_ff[30:1]};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd30) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = acc_ff[61:0];
endmodule

/* hw/rtl/tma_div.sv */
module tma_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [62:0] dividend,
   input  logic [46:0] divisor,
   output logic        done,
   output logic [62:0] quotient
);
   logic [46:0] rem_ff, rem_in;
   logic [62:0] quo_ff, quo_in;
   logic [46:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [47:0] trial;
   logic [47:0] diff;
   logic        ge;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[62]};
      diff  = trial - {1'b0, den_ff};
      ge    = trial >= {1'b0, den_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[46:0] : trial[46:0];
         quo_in = {quo_ff[61:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd62) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* hw/rtl/tma_sqrt.sv */
module tma_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [61:0] radicand,
   output logic        done,
   output logic [30:0] root
);
   logic [61:0] x_ff, x_in;
   logic [61:0] r_ff, r_in;
   logic [61:0] bit_ff, bit_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [62:0] cand;

   always_comb begin
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cand = {1'b0, r_ff} + {1'b0, bit_ff};
      if (start) begin
         x_in    = radicand;
         r_in    = '0;
         bit_in  = {2'b01, 60'd0};
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, x_ff} >= cand) begin
            x_in = x_ff - cand[61:0];
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd30) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[30:0];
endmodule

/* tb/tma_checker.sv */
`timescale 1ns / 1ps

module tma_checker (
   input  logic  clock,
   input  logic  reset,
   tma_req_if    req_mon,
   tma_rsp_if    rsp_mon,
   output int    fail_count,
   output int    pending
);
   import tma_pkg::*;

   localparam int      SLOTS  = 1024;
   localparam longint  ACC_HI = 64'sd140737488355327;
   localparam longint  ACC_LO = -ACC_HI - 64'sd1;
   localparam longint  SAT_HI = 64'sd2147483647;

   typedef struct {
      q14_type x;
      q14_type y;
      q14_type z;
      logic    zero;
   } tangent_word_type;

   longint vx[SLOTS], vy[SLOTS], vz[SLOTS], vu[SLOTS], vv[SLOTS];
   longint tx_acc[SLOTS], ty_acc[SLOTS], tz_acc[SLOTS];

   tangent_word_type expected_tangents[$];

   assign pending = expected_tangents.size();

   function automatic logic [63:0] abs64(input longint v);
      abs64 = v < 0 ? 64'd0 - 64'(v) : 64'(v);
   endfunction

   function automatic longint clip31(input longint v);
      if (v > SAT_HI) clip31 = SAT_HI;
      else if (v < -SAT_HI) clip31 = -SAT_HI;
      else clip31 = v;
   endfunction

   function automatic longint fx_mul(input longint a, input longint b);
      logic [63:0] m;
      m = (abs64(a) * abs64(b)) >> 16;
      fx_mul = ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint fx_div(input longint num, input longint den);
      logic [63:0] q;
      q = (abs64(num) << 16) / abs64(den);
      if ((num < 0) != (den < 0))
         fx_div = (q > 64'(ACC_HI) + 64'd1) ? ACC_LO : -longint'(q);
      else
         fx_div = (q > 64'(ACC_HI)) ? ACC_HI : longint'(q);
   endfunction

   function automatic longint acc_sum(input longint a, input longint b);
      longint s;
      s = a + b;
      if (s > ACC_HI) acc_sum = ACC_HI;
      else if (s < ACC_LO) acc_sum = ACC_LO;
      else acc_sum = s;
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      root_floor = r;
   endfunction

   function automatic q14_type unit_comp(input longint acc, input logic [63:0] m,
                                         input logic [63:0] len);
      logic [63:0] q;
      q = (m * 64'd16384) / len;
      if (acc < 0) q = 64'd0 - q;
      unit_comp = q[15:0];
   endfunction

   task automatic add_triangle(input int a, input int b, input int c);
      longint e1x, e1y, e1z, e2x, e2y, e2z, du1, dv1, du2, dv2, det, tx, ty, tz;
      int corner[3];
      e1x = clip31(vx[b] - vx[a]);
      e1y = clip31(vy[b] - vy[a]);
      e1z = clip31(vz[b] - vz[a]);
      e2x = clip31(vx[c] - vx[a]);
      e2y = clip31(vy[c] - vy[a]);
      e2z = clip31(vz[c] - vz[a]);
      du1 = clip31(vu[b] - vu[a]);
      dv1 = clip31(vv[b] - vv[a]);
      du2 = clip31(vu[c] - vu[a]);
      dv2 = clip31(vv[c] - vv[a]);
      det = fx_mul(du1, dv2) - fx_mul(du2, dv1);
      if (det == 0) return;
      tx = fx_div(fx_mul(dv2, e1x) - fx_mul(dv1, e2x), det);
      ty = fx_div(fx_mul(dv2, e1y) - fx_mul(dv1, e2y), det);
      tz = fx_div(fx_mul(dv2, e1z) - fx_mul(dv1, e2z), det);
      corner[0] = a;
      corner[1] = b;
      corner[2] = c;
      foreach (corner[i]) begin
         tx_acc[corner[i]] = acc_sum(tx_acc[corner[i]], tx);
         ty_acc[corner[i]] = acc_sum(ty_acc[corner[i]], ty);
         tz_acc[corner[i]] = acc_sum(tz_acc[corner[i]], tz);
      end
   endtask

   function automatic tangent_word_type unit_tangent(input int s);
      tangent_word_type w;
      logic [63:0] mx, my, mz, len;
      w = '{x: 0, y: 0, z: 0, zero: 1'b1};
      mx = abs64(tx_acc[s]);
      my = abs64(ty_acc[s]);
      mz = abs64(tz_acc[s]);
      if ((mx | my | mz) == 0) return w;
      while (mx >= (64'd1 << 30) || my >= (64'd1 << 30) || mz >= (64'd1 << 30)) begin
         mx = mx >> 1;
         my = my >> 1;
         mz = mz >> 1;
      end
      len = root_floor(mx * mx + my * my + mz * mz);
      if (len == 0) return w;
      w.x = unit_comp(tx_acc[s], mx, len);
      w.y = unit_comp(ty_acc[s], my, len);
      w.z = unit_comp(tz_acc[s], mz, len);
      w.zero = 1'b0;
      return w;
   endfunction

   always @(posedge clock) begin
      tangent_word_type want;
      int s;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_tangents.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected word x=%0d y=%0d z=%0d zero=%0b", $realtime,
                           rsp_mon.tangent_x, rsp_mon.tangent_y, rsp_mon.tangent_z,
                           rsp_mon.is_zero);
            end else begin
               want = expected_tangents.pop_front();
               if (rsp_mon.tangent_x !== want.x || rsp_mon.tangent_y !== want.y ||
                   rsp_mon.tangent_z !== want.z || rsp_mon.is_zero !== want.zero) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: exp %0d %0d %0d zero=%0b, got %0d %0d %0d zero=%0b",
                              $realtime, want.x, want.y, want.z, want.zero,
                              rsp_mon.tangent_x, rsp_mon.tangent_y, rsp_mon.tangent_z,
                              rsp_mon.is_zero);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            s = int'(req_mon.vertex_index);
            case (req_mon.cmd)
               CMD_LOAD: begin
                  vx[s] = longint'(req_mon.pos_x);
                  vy[s] = longint'(req_mon.pos_y);
                  vz[s] = longint'(req_mon.pos_z);
                  vu[s] = longint'(req_mon.tex_u);
                  vv[s] = longint'(req_mon.tex_v);
                  tx_acc[s] = 0;
                  ty_acc[s] = 0;
                  tz_acc[s] = 0;
               end
               CMD_TRI:
                  add_triangle(int'(req_mon.corner_a), int'(req_mon.corner_b),
                               int'(req_mon.corner_c));
               CMD_READ:
                  expected_tangents.push_back(unit_tangent(s));
               default: ;
            endcase
         end
      end
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import tma_pkg::*;

   localparam logic [1:0] CMD_NOP     = 2'd3;
   localparam int         RANDOM_ITEMS = 1950;
   localparam longint     CYCLE_LIMIT  = 8000000;

   logic   clock = 1'b0;
   logic   reset = 1'b1;
   int     fail_count, pending;
   int     idle_mode = 0;
   longint cycles = 0;
   bit     loaded[1024];
   int     loaded_slots[$];

   tma_req_if req_ch ();
   tma_rsp_if rsp_ch ();

   mesh_tangent_accumulate_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   tma_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      case (idle_mode)
         2:       rsp_ch.ready <= $urandom_range(0, 99) >= 87;
         3:       rsp_ch.ready <= $urandom_range(0, 99) >= 17;
         default: rsp_ch.ready <= 1'b1;
      endcase
   end

   function automatic q16_type rand_q16();
      case ($urandom_range(0, 9))
         0:       rand_q16 = $urandom;
         1:       rand_q16 = 32'sh7FFF_FFFF;
         2:       rand_q16 = 32'sh8000_0000;
         default: rand_q16 = $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
      endcase
   endfunction

   function automatic int any_loaded();
      any_loaded = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
   endfunction

   task automatic send_word(input logic [1:0] cmd, input int slot,
                            input q16_type x, input q16_type y, input q16_type z,
                            input q16_type u, input q16_type v,
                            input int a, input int b, input int c);
      int gap;
      gap = 0;
      if (idle_mode == 1 || idle_mode == 3)
         while ($urandom_range(0, 99) < ((idle_mode == 1) ? 87 : 17) && gap < 60)
            gap++;
      repeat (gap) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= cmd;
      req_ch.vertex_index <= 10'(slot);
      req_ch.pos_x        <= x;
      req_ch.pos_y        <= y;
      req_ch.pos_z        <= z;
      req_ch.tex_u        <= u;
      req_ch.tex_v        <= v;
      req_ch.corner_a     <= 10'(a);
      req_ch.corner_b     <= 10'(b);
      req_ch.corner_c     <= 10'(c);
      do @(posedge clock); while (!req_ch.ready);
      if (cmd == CMD_LOAD && !loaded[slot]) begin
         loaded[slot] = 1'b1;
         loaded_slots.push_back(slot);
      end
   endtask

   task automatic load_vertex(input int slot, input q16_type x, input q16_type y,
                              input q16_type z, input q16_type u, input q16_type v);
      send_word(CMD_LOAD, slot, x, y, z, u, v, $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 1023));
   endtask

   task automatic add_tri(input int a, input int b, input int c);
      send_word(CMD_TRI, $urandom_range(0, 1023), $urandom, $urandom, $urandom,
                $urandom, $urandom, a, b, c);
   endtask

   task automatic read_tangent(input int slot);
      send_word(CMD_READ, slot, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
   endtask

   initial begin
      int pick, slot;
      req_ch.valid        = 1'b0;
      req_ch.cmd          = CMD_LOAD;
      req_ch.vertex_index = '0;
      req_ch.pos_x        = '0;
      req_ch.pos_y        = '0;
      req_ch.pos_z        = '0;
      req_ch.tex_u        = '0;
      req_ch.tex_v        = '0;
      req_ch.corner_a     = '0;
      req_ch.corner_b     = '0;
      req_ch.corner_c     = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_vertex(0, 0, 0, 0, 0, 0);
      load_vertex(1, 32'sh1_0000, 0, 0, 32'sh1_0000, 0);
      load_vertex(2, 0, 32'sh1_0000, 0, 0, 32'sh1_0000);
      read_tangent(0);
      add_tri(0, 1, 2);
      read_tangent(0);
      read_tangent(1);
      load_vertex(1023, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 32'sh7FFF_FFFF);
      load_vertex(3, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  32'sh7FFF_FFFF, 32'sh8000_0000);
      load_vertex(4, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  32'sh0000_0001, 32'sh7FFF_FFFF);
      add_tri(1023, 3, 4);
      add_tri(1023, 3, 4);
      read_tangent(1023);
      read_tangent(4);
      load_vertex(5, 32'sh3_0000, 0, 0, 32'sh2_0000, 32'sh2_0000);
      add_tri(0, 5, 5);
      add_tri(2, 2, 1);
      read_tangent(2);
      add_tri(0, 1, 0);
      read_tangent(5);
      send_word(CMD_NOP, 0, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
      load_vertex(0, 0, 0, 0, 0, 0);
      read_tangent(0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_mode = (n / (RANDOM_ITEMS / 8)) % 4;
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            slot = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, 31);
            load_vertex(slot, rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16());
         end else if (pick < 62) begin
            add_tri(any_loaded(), any_loaded(), any_loaded());
         end else if (pick < 95) begin
            read_tangent(any_loaded());
         end else begin
            send_word(CMD_NOP, $urandom_range(0, 1023), $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom_range(0, 1023),
                      $urandom_range(0, 1023), $urandom_range(0, 1023));
         end
      end
      req_ch.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/tma_pkg.sv
hw/rtl/tma_req_if.sv
hw/rtl/tma_rsp_if.sv
hw/rtl/tma_mul.sv
hw/rtl/tma_div.sv
hw/rtl/tma_sqrt.sv
hw/rtl/mesh_tangent_accumulate_top.sv
tb/tma_checker.sv
tb/testbench.sv
